/* design/icr_pkg.sv */
package icr_pkg;

    // Item kinds carried on s_tuser
    localparam logic FUNC_FRAME    = 1'b0;
    localparam logic FUNC_CAM_SYNC = 1'b1;

    // Frame identifier that gets rewritten
    localparam logic [7:0] FRAME_INJ = 8'h20;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUEL_LEVEL     = 2'd0;
    localparam logic [1:0] CFG_TIMING_MODE    = 2'd1;
    localparam logic [1:0] CFG_KILL_CYLINDER  = 2'd2;
    localparam logic [1:0] CFG_THREE_CYL      = 2'd3;

    // Timing modes
    localparam logic [2:0] TMODE_STOCK   = 3'd0;
    localparam logic [2:0] TMODE_RETARD  = 3'd1;
    localparam logic [2:0] TMODE_ADVANCE = 3'd2;
    localparam logic [2:0] TMODE_HS_ADV  = 3'd3;
    localparam logic [2:0] TMODE_STATIC  = 3'd4;

    // Arithmetic constants
    localparam logic [16:0] CMD_MAX       = 17'd4093;
    localparam logic [16:0] TIMING_STEP   = 17'd256;
    localparam logic [16:0] TIMING_STATIC = 17'd1920;
    localparam logic [16:0] IDLE_ADD      = 17'd500;
    localparam logic [15:0] FUEL_TH1      = 16'h0300;
    localparam logic [15:0] FUEL_TH2      = 16'h0400;
    localparam logic [15:0] FUEL_TH3      = 16'h0A00;
    localparam logic [13:0] RPM_TH2       = 14'd1400;
    localparam logic [13:0] RPM_TH3       = 14'd1700;
    localparam logic [13:0] RPM_HS_ADV    = 14'd2200;
    localparam logic [13:0] RPM_IDLE      = 14'd1050;
    localparam logic [9:0]  PEDAL_TH      = 10'd200;

    // Configuration register set
    typedef struct packed {
        logic [1:0] fuel_level;
        logic [2:0] timing_mode;
        logic [2:0] kill_cylinder;
        logic       three_cylinder_enable;
    } cfg_t;

    // Step tracker result for one request
    typedef struct packed {
        logic       inject;
        logic [2:0] cylinder;
    } step_info_t;

    // Firing order lookup by step 1..6
    function automatic logic [2:0] firing_order(input logic [2:0] step);
        logic [2:0] cyl;
        case (step)
            3'd1: cyl = 3'd1;
            3'd2: cyl = 3'd5;
            3'd3: cyl = 3'd3;
            3'd4: cyl = 3'd6;
            3'd5: cyl = 3'd2;
            3'd6: cyl = 3'd4;
            default: cyl = 3'd0;
        endcase
        return cyl;
    endfunction

    // Clamp to the top of the command range
    function automatic logic [11:0] sat_top(input logic [16:0] v);
        logic [11:0] r;
        if (v > CMD_MAX) begin
            r = CMD_MAX[11:0];
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

/* design/injection_command_rewriter.sv */
// Injection command rewriter.
// Input stream (s_*): one request per received frame or cam-sync pulse.
// s_tuser is the item kind (0 frame, 1 cam sync); s_tdata packs the frame
// identifier, raw fuel, raw timing, engine speed and pedal reading.
// Output stream (m_*): one request for each frame with identifier 0x20,
// carrying rewritten fuel, rewritten timing and the cylinder number.
// Cam-sync pulses and other frames only update the cylinder step or pass.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge.
// A request passes the input register, then the fuel/timing logic into the
// output register, which drives m_tvalid and m_tdata.
// Throughput is one request per cycle while the receiver does not stall; both stages advance together.
// When the receiver stalls, the output register holds and the input
// register still takes one more 0x20 frame (other requests pass freely)
// before s_tready drops.
// Reset clears all configuration registers, the cylinder step and both
// valid flags; the block accepts requests as soon as reset is released.
module injection_command_rewriter
    import icr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // frame_id[7:0], fuel_raw[23:8], timing_raw[39:24],
                                  // engine_rpm[53:40], pedal_position[63:54]
    input  logic        s_tuser,  // func[0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // fuel_out[11:0], timing_out[23:12],
                                  // cylinder_number[26:24], zero[31:27]
);

    cfg_t        cfg_reg;
    step_info_t  step_info;
    logic        s_accept;
    logic        advance;

    // Input register
    logic        in_valid_reg;
    logic [15:0] fuel_raw_reg;
    logic [15:0] timing_raw_reg;
    logic [13:0] rpm_reg;
    logic [9:0]  pedal_reg;
    logic [2:0]  cyl_reg;

    // Result register
    logic        out_valid_reg;
    logic [11:0] fuel_out_reg;
    logic [11:0] timing_out_reg;
    logic [2:0]  cyl_out_reg;

    logic [11:0] fuel_calc;
    logic [11:0] timing_calc;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FUEL_LEVEL:    cfg_reg.fuel_level            <= cfg_data[1:0];
                CFG_TIMING_MODE:   cfg_reg.timing_mode           <= cfg_data;
                CFG_KILL_CYLINDER: cfg_reg.kill_cylinder         <= cfg_data;
                CFG_THREE_CYL:     cfg_reg.three_cylinder_enable <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: both stages move when the output register frees up
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    icr_step_tracker u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .func     (s_tuser),
        .frame_id (s_tdata[7:0]),
        .info     (step_info)
    );

    // Input stage: keep only requests that produce a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_accept && step_info.inject;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            fuel_raw_reg   <= s_tdata[23:8];
            timing_raw_reg <= s_tdata[39:24];
            rpm_reg        <= s_tdata[53:40];
            pedal_reg      <= s_tdata[63:54];
            cyl_reg        <= step_info.cylinder;
        end
    end

    icr_fuel_calc u_fuel (
        .cfg            (cfg_reg),
        .fuel_raw       (fuel_raw_reg),
        .engine_rpm     (rpm_reg),
        .pedal_position (pedal_reg),
        .cylinder       (cyl_reg),
        .fuel_out       (fuel_calc)
    );

    icr_timing_calc u_timing (
        .cfg        (cfg_reg),
        .timing_raw (timing_raw_reg),
        .engine_rpm (rpm_reg),
        .timing_out (timing_calc)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fuel_out_reg   <= fuel_calc;
            timing_out_reg <= timing_calc;
            cyl_out_reg    <= cyl_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, cyl_out_reg, timing_out_reg, fuel_out_reg};

endmodule

/* design/icr_step_tracker.sv */
module icr_step_tracker
    import icr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic       func,
    input  logic [7:0] frame_id,
    output step_info_t info
);

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [2:0] step_adv;
    logic       is_inj;

    assign is_inj = (func == FUNC_FRAME) && (frame_id == FRAME_INJ);

    // Advance 1..6, anything else restarts at 1
    always_comb begin
        step_adv = step_reg + 3'd1;
        if (step_adv > 3'd6 || step_adv == 3'd0) begin
            step_adv = 3'd1;
        end
    end

    always_comb begin
        step_next = step_reg;
        if (accept) begin
            if (func == FUNC_CAM_SYNC) begin
                step_next = 3'd1;
            end else if (is_inj) begin
                step_next = step_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
        end else begin
            step_reg <= step_next;
        end
    end

    assign info.inject   = is_inj;
    assign info.cylinder = firing_order(step_adv);

endmodule

/* design/icr_fuel_calc.sv */
module icr_fuel_calc
    import icr_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [15:0] fuel_raw,
    input  logic [13:0] engine_rpm,
    input  logic [9:0]  pedal_position,
    input  logic [2:0]  cylinder,
    output logic [11:0] fuel_out
);

    logic [16:0] raw_w;
    logic [16:0] f;

    assign raw_w = {1'b0, fuel_raw};

    // Staged boost, pedal override, cuts; later stages win
    always_comb begin
        f = raw_w;
        if (fuel_raw > FUEL_TH1 && cfg.fuel_level > 2'd0) begin
            f = raw_w + {4'd0, fuel_raw[15:3]};
        end
        if (fuel_raw > FUEL_TH2 && cfg.fuel_level > 2'd0 && engine_rpm > RPM_TH2) begin
            f = raw_w + {3'd0, fuel_raw[15:2]};
        end
        if (fuel_raw > FUEL_TH3 && cfg.fuel_level > 2'd1 && engine_rpm > RPM_TH3) begin
            f = raw_w + {2'd0, fuel_raw[15:1]};
        end
        if (cfg.fuel_level > 2'd2) begin
            if (pedal_position > PEDAL_TH) begin
                f = {7'd0, pedal_position} + {6'd0, pedal_position, 1'b0};
            end else begin
                f = {6'd0, pedal_position, 1'b0};
            end
        end
        if (cylinder == cfg.kill_cylinder) begin
            f = 17'd0;
        end
        // Three-cylinder idle: cylinders 1, 2 and 3 cut
        if (cfg.three_cylinder_enable && engine_rpm < RPM_IDLE) begin
            f = raw_w + IDLE_ADD;
            if (cylinder == 3'd1 || cylinder == 3'd3 || cylinder == 3'd2) begin
                f = 17'd0;
            end
        end
    end

    assign fuel_out = sat_top(f);

endmodule

/* design/icr_timing_calc.sv */
module icr_timing_calc
    import icr_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [15:0] timing_raw,
    input  logic [13:0] engine_rpm,
    output logic [11:0] timing_out
);

    logic [16:0] raw_w;
    logic [16:0] t;

    assign raw_w = {1'b0, timing_raw};

    // Mode select; retard floors at zero
    always_comb begin
        t = raw_w;
        case (cfg.timing_mode)
            TMODE_RETARD: begin
                t = (raw_w >= TIMING_STEP) ? raw_w - TIMING_STEP : 17'd0;
            end
            TMODE_ADVANCE: begin
                t = raw_w + TIMING_STEP;
            end
            TMODE_HS_ADV: begin
                if (engine_rpm > RPM_HS_ADV) begin
                    t = raw_w + TIMING_STEP;
                end
            end
            TMODE_STATIC: begin
                t = TIMING_STATIC;
            end
            default: begin
                t = raw_w;
            end
        endcase
    end

    assign timing_out = sat_top(t);

endmodule
